// ===== design/utfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package utfp_pkg;

	// string limits and counter widths
	localparam int unsigned MAX_UNITS = 1024;
	localparam int unsigned UNITS_W   = 11;
	localparam int unsigned CNT_W     = 17;
	localparam int unsigned NRES      = 5;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [15:0] BUF_SIZE_RST = 16'd1024;

	// code point constants
	localparam logic [20:0] CP_REPLACE = 21'h00FFFD;
	localparam logic [20:0] CP_SUPP    = 21'h010000;
	localparam logic [7:0]  CH_BSLASH  = 8'h5C;
	localparam logic [7:0]  CH_SLASH   = 8'h2F;

	// result status codes
	typedef enum logic [1:0] {
		ST_BUSY  = 2'd0,
		ST_OK    = 2'd1,
		ST_RANGE = 2'd2
	} utfp_status_t;

	// encoded code point: byte count and bytes, first byte in slot 0
	typedef struct packed {
		logic [2:0]      len;
		logic [3:0][7:0] bytes;
	} utfp_enc_t;

	// add a small offset to the byte count, clamping at its ceiling
	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] base,
			input logic [2:0] inc);
		logic [CNT_W:0] sum;
		sum = {1'b0, base} + {{(CNT_W-2){1'b0}}, inc};
		if (sum > {1'b0, CNT_MAX})
			return CNT_MAX;
		return sum[CNT_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== design/utf16_path_to_utf8.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted item passes through the input register, then the result buffer.
// Results leave one per cycle while out_stall is low; an item has zero to five
// results, and one that has none never loads the result buffer.
// The result buffer is reloaded in the cycle its last result is taken.
// Reset: buffer_size returns to 1024, string state and both stages empty.
module utf16_path_to_utf8 import utfp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] code_unit,
	input  wire logic        end_of_string,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic [15:0]      out_index,
	output logic             stored,
	output logic             is_last,
	output logic [1:0]       status
);

	logic [15:0]        buf_size_q;
	logic               valid_s1;
	logic [15:0]        unit_s1;
	logic               eos_s1;
	logic [15:0]        pend_unit_q, pend_unit_d;
	logic               pend_valid_q, pend_valid_d;
	logic [CNT_W-1:0]   bytes_q, bytes_d;
	logic [UNITS_W-1:0] units_q, units_d;
	logic               buf_valid_q;
	logic [2:0]         rd_q, last_q;
	logic [7:0]         byte_q   [NRES];
	logic [15:0]        idx_q    [NRES];
	logic               stored_q [NRES];
	utfp_status_t       status_q [NRES];

	logic               have;
	logic [20:0]        cp;
	utfp_enc_t          enc;
	logic [2:0]         nbytes, nres;
	logic [CNT_W-1:0]   bytes_end;
	logic               term_ok;
	logic [7:0]         ld_byte   [NRES];
	logic [15:0]        ld_idx    [NRES];
	logic               ld_stored [NRES];
	utfp_status_t       ld_status [NRES];
	logic [CNT_W-1:0]   ld_cnt;
	logic               out_take, buf_free, consume;

	// handshake: the input register moves on when the result buffer frees up
	assign out_valid = buf_valid_q;
	assign out_take  = buf_valid_q && !out_stall;
	assign is_last   = (rd_q == last_q);
	assign buf_free  = !buf_valid_q || (out_take && is_last);
	assign consume   = valid_s1 && buf_free;
	assign in_stall  = valid_s1 && !buf_free;

	assign out_byte  = byte_q[rd_q];
	assign out_index = idx_q[rd_q];
	assign stored    = stored_q[rd_q];
	assign status    = status_q[rd_q];

	// hold the config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			buf_size_q <= BUF_SIZE_RST;
		else if (cfg_wr_en)
			buf_size_q <= cfg_wr_data;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!valid_s1 || buf_free)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			unit_s1 <= code_unit;
			eos_s1  <= end_of_string;
		end
	end

	// surrogate pairing and unit counting
	always_comb begin
		have         = 1'b0;
		cp           = '0;
		pend_valid_d = pend_valid_q;
		pend_unit_d  = pend_unit_q;
		units_d      = units_q;
		if (units_q > UNITS_W'(MAX_UNITS)) begin
			units_d = units_q;
		end else if (units_q == UNITS_W'(MAX_UNITS)) begin
			units_d      = UNITS_W'(MAX_UNITS + 1);
			pend_valid_d = 1'b0;
			pend_unit_d  = '0;
		end else begin
			units_d = units_q + 1'b1;
			if (pend_valid_q) begin
				pend_valid_d = 1'b0;
				pend_unit_d  = '0;
				have         = 1'b1;
				if (pend_unit_q[15:10] == 6'b110110 && unit_s1[15:10] == 6'b110111)
					cp = {1'b0, pend_unit_q[9:0], unit_s1[9:0]} + CP_SUPP;
				else
					cp = CP_REPLACE;
			end else if (unit_s1[15:11] == 5'b11011) begin
				if (eos_s1) begin
					cp   = CP_REPLACE;
					have = 1'b1;
				end else begin
					pend_unit_d  = unit_s1;
					pend_valid_d = 1'b1;
				end
			end else begin
				cp   = {5'd0, unit_s1};
				have = 1'b1;
			end
		end
	end

	utfp_enc u_enc (
		.cp  (cp),
		.enc (enc)
	);

	// lay out the results of this item: data bytes, then the terminator
	always_comb begin
		nbytes    = have ? enc.len : 3'd0;
		nres      = nbytes + {2'd0, eos_s1};
		bytes_end = sat_add(bytes_q, nbytes);
		term_ok   = (units_d <= UNITS_W'(MAX_UNITS)) && (bytes_end < {1'b0, buf_size_q});
		for (int j = 0; j < NRES; j++) begin
			ld_cnt = sat_add(bytes_q, 3'(j));
			if (3'(j) < nbytes) begin
				ld_byte[j]   = enc.bytes[j[1:0]];
				ld_idx[j]    = ld_cnt[15:0];
				ld_stored[j] = (ld_cnt < {1'b0, buf_size_q});
				ld_status[j] = ST_BUSY;
			end else begin
				ld_byte[j]   = 8'd0;
				ld_idx[j]    = bytes_end[15:0];
				ld_stored[j] = term_ok;
				ld_status[j] = term_ok ? ST_OK : ST_RANGE;
			end
		end
		if (eos_s1) begin
			bytes_d = '0;
		end else begin
			bytes_d = bytes_end;
		end
	end

	// advance string state; clear it at the end of a path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_unit_q  <= '0;
			pend_valid_q <= 1'b0;
			bytes_q      <= '0;
			units_q      <= '0;
		end else if (consume) begin
			bytes_q <= bytes_d;
			if (eos_s1) begin
				pend_unit_q  <= '0;
				pend_valid_q <= 1'b0;
				units_q      <= '0;
			end else begin
				pend_unit_q  <= pend_unit_d;
				pend_valid_q <= pend_valid_d;
				units_q      <= units_d;
			end
		end
	end

	// result buffer control: load, step through, drop when drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
			rd_q        <= '0;
			last_q      <= '0;
		end else if (consume && nres != 3'd0) begin
			buf_valid_q <= 1'b1;
			rd_q        <= '0;
			last_q      <= nres - 1'b1;
		end else if (out_take) begin
			if (is_last)
				buf_valid_q <= 1'b0;
			else
				rd_q <= rd_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && nres != 3'd0) begin
			for (int j = 0; j < NRES; j++) begin
				byte_q[j]   <= ld_byte[j];
				idx_q[j]    <= ld_idx[j];
				stored_q[j] <= ld_stored[j];
				status_q[j] <= ld_status[j];
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/utfp_enc.sv =====
`timescale 1ns / 1ps
`default_nettype none
module utfp_enc import utfp_pkg::*; (
	input  wire logic [20:0] cp,
	output utfp_enc_t        enc
);

	// pick the UTF-8 form by code point range; backslash maps to slash
	always_comb begin
		enc = '0;
		if (cp < 21'h80) begin
			enc.len      = 3'd1;
			enc.bytes[0] = (cp[7:0] == CH_BSLASH) ? CH_SLASH : cp[7:0];
		end else if (cp < 21'h800) begin
			enc.len      = 3'd2;
			enc.bytes[0] = {3'b110, cp[10:6]};
			enc.bytes[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			enc.len      = 3'd3;
			enc.bytes[0] = {4'b1110, cp[15:12]};
			enc.bytes[1] = {2'b10, cp[11:6]};
			enc.bytes[2] = {2'b10, cp[5:0]};
		end else begin
			enc.len      = 3'd4;
			enc.bytes[0] = {5'b11110, cp[20:18]};
			enc.bytes[1] = {2'b10, cp[17:12]};
			enc.bytes[2] = {2'b10, cp[11:6]};
			enc.bytes[3] = {2'b10, cp[5:0]};
		end
	end

endmodule
`default_nettype wire

// ===== design/utfp_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
module utfp_chk import utfp_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  out_byte,
	input wire logic [15:0] out_index,
	input wire logic        stored,
	input wire logic        is_last,
	input wire logic [1:0]  status
);

	// a stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_index))
		else $error("stalled result item changed");

	// only the last result of an item closes a string
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_BUSY |-> is_last)
		else $error("final status on a non-last result");

	// a good terminator is a stored NUL
	a_ok_nul: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> stored && out_byte == 8'd0)
		else $error("finished ok without a stored NUL");

	// a range error never writes the buffer
	a_range_nostore: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_RANGE |-> !stored && out_byte == 8'd0)
		else $error("range error result stored");

	// within a string, consecutive results advance the index by one
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && status == ST_BUSY ##1 out_valid
			|-> out_index == $past(out_index) + 16'd1)
		else $error("result index did not advance");

endmodule

bind utf16_path_to_utf8 utfp_chk u_utfp_chk (.*);
`default_nettype wire
